/* rtl/fir_pkg.sv */
// ----------------------------------------------------------------------------
// FIR filter package
// Shared sizes, codes and the command and status bundles of the FIR filter.
// ----------------------------------------------------------------------------
package fir_pkg;

  localparam int TAPS        = 256;
  localparam int SAMPLE_BITS = 24;
  localparam int TAP_W       = $clog2(TAPS);
  localparam int CNT_W       = TAP_W + 1;
  localparam int TAPCNT_W    = 9;
  localparam int IDX_W       = 8;
  localparam int KIND_W      = 2;
  localparam int PROD_W      = 2 * SAMPLE_BITS;
  localparam int ACC_W       = PROD_W + TAP_W;
  localparam int FRAC        = SAMPLE_BITS - 1;
  localparam int DRAIN_CYCLES = 2;
  localparam int DRAIN_W     = (DRAIN_CYCLES > 1) ? $clog2(DRAIN_CYCLES) : 1;

  typedef enum logic [KIND_W-1:0] {
    KIND_FILTER = 2'd0,
    KIND_LOAD   = 2'd1,
    KIND_CLEAR  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MAC,
    S_DRAIN,
    S_OUT
  } state_t;

  typedef struct packed {
    logic             hist_wr;
    logic             coef_wr;
    logic             hist_clr;
    logic             mac_start;
    logic             issue;
    logic [TAP_W-1:0] tap_k;
    logic             load_out;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } sts_t;

endpackage

/* rtl/fir_ctrl.sv */
// ----------------------------------------------------------------------------
// FIR filter controller
// Decodes requests, holds the tap count and sequences the multiply-accumulate.
// ----------------------------------------------------------------------------
module fir_ctrl (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [fir_pkg::KIND_W-1:0]       in_kind,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fir_pkg::TAPCNT_W-1:0]     cfg_data,
  input  fir_pkg::sts_t                    sts,
  output fir_pkg::cmd_t                    cmd
);

  fir_pkg::state_t                state_r, state_nxt;
  logic [fir_pkg::CNT_W-1:0]      k_r, k_nxt;
  logic [fir_pkg::DRAIN_W-1:0]    drain_r, drain_nxt;
  logic [fir_pkg::TAPCNT_W-1:0]   tap_count_r;
  logic [fir_pkg::CNT_W-1:0]      n_eff;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_count_r <= fir_pkg::TAPCNT_W'(1);
    end else if (cfg_valid) begin
      tap_count_r <= cfg_data;
    end
  end

  // A tap count of zero runs one tap; counts beyond the array run all taps.
  always_comb begin
    if (tap_count_r == '0) begin
      n_eff = fir_pkg::CNT_W'(1);
    end else if (32'(tap_count_r) > fir_pkg::TAPS) begin
      n_eff = fir_pkg::CNT_W'(fir_pkg::TAPS);
    end else begin
      n_eff = fir_pkg::CNT_W'(tap_count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fir_pkg::S_IDLE;
      k_r     <= '0;
      drain_r <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      drain_r <= drain_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    drain_nxt = drain_r;
    cmd       = '0;
    cmd.tap_k = k_r[fir_pkg::TAP_W-1:0];
    in_ready  = (state_r == fir_pkg::S_IDLE);
    unique case (state_r)
      fir_pkg::S_IDLE: begin
        if (in_valid) begin
          unique case (fir_pkg::kind_t'(in_kind))
            fir_pkg::KIND_FILTER: begin
              cmd.hist_wr   = 1'b1;
              cmd.mac_start = 1'b1;
              k_nxt         = '0;
              state_nxt     = fir_pkg::S_MAC;
            end
            fir_pkg::KIND_LOAD:  cmd.coef_wr  = 1'b1;
            fir_pkg::KIND_CLEAR: cmd.hist_clr = 1'b1;
            default: ;
          endcase
        end
      end
      fir_pkg::S_MAC: begin
        cmd.issue = 1'b1;
        k_nxt     = k_r + fir_pkg::CNT_W'(1);
        if (k_r == n_eff - fir_pkg::CNT_W'(1)) begin
          drain_nxt = '0;
          state_nxt = fir_pkg::S_DRAIN;
        end
      end
      fir_pkg::S_DRAIN: begin
        drain_nxt = drain_r + fir_pkg::DRAIN_W'(1);
        if (32'(drain_r) == fir_pkg::DRAIN_CYCLES - 1) begin
          state_nxt = fir_pkg::S_OUT;
        end
      end
      fir_pkg::S_OUT: begin
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = fir_pkg::S_IDLE;
        end
      end
      default: state_nxt = fir_pkg::S_IDLE;
    endcase
  end

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !sts.out_busy)
    else $error("result loaded while the output register is still held");

  a_start_enters_mac: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mac_start |=> (state_r == fir_pkg::S_MAC) && (k_r == '0))
    else $error("sample request did not start the tap sweep at tap zero");

  a_tap_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fir_pkg::S_MAC) |-> (k_r < n_eff))
    else $error("tap counter ran past the tap count");

endmodule

/* rtl/fir_datapath.sv */
// ----------------------------------------------------------------------------
// FIR filter datapath
// Coefficient and history memories, multiplier, accumulator, rounding and the
// output register.
// ----------------------------------------------------------------------------
module fir_datapath (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  fir_pkg::cmd_t                          cmd,
  input  logic [fir_pkg::IDX_W-1:0]              in_coef_index,
  input  logic signed [fir_pkg::SAMPLE_BITS-1:0] in_value,
  input  logic                                   out_ready,
  output logic                                   out_valid,
  output logic signed [fir_pkg::SAMPLE_BITS-1:0] out_filtered,
  output logic                                   out_clipped,
  output fir_pkg::sts_t                          sts
);

  localparam logic [fir_pkg::TAP_W-1:0] LAST_POS = fir_pkg::TAP_W'(fir_pkg::TAPS - 1);

  logic signed [fir_pkg::SAMPLE_BITS-1:0] coef_mem [fir_pkg::TAPS];
  logic signed [fir_pkg::SAMPLE_BITS-1:0] hist_mem [fir_pkg::TAPS];
  logic [fir_pkg::TAPS-1:0]               hvalid_r;
  logic [fir_pkg::TAP_W-1:0]              newest_r, pos_r, next_pos;

  logic                                   rd_v_r, hq_ok_r, prod_v_r;
  logic signed [fir_pkg::SAMPLE_BITS-1:0] hist_q_r, coef_q_r, hist_eff;
  logic signed [fir_pkg::PROD_W-1:0]      prod_r;
  logic signed [fir_pkg::ACC_W-1:0]       acc_r, rnd;
  logic                                   fits;
  logic signed [fir_pkg::SAMPLE_BITS-1:0] sat_val;

  logic                                   out_valid_r;
  logic signed [fir_pkg::SAMPLE_BITS-1:0] out_filtered_r;
  logic                                   out_clipped_r;

  assign next_pos = (newest_r == LAST_POS) ? '0 : newest_r + fir_pkg::TAP_W'(1);

  // Memories. History entries that were never written since reset or the
  // last clear read as zero through their valid bit.
  always_ff @(posedge clk) begin
    if (cmd.coef_wr && (32'(in_coef_index) < fir_pkg::TAPS)) begin
      coef_mem[fir_pkg::TAP_W'(in_coef_index)] <= in_value;
    end
    if (cmd.hist_wr) begin
      hist_mem[next_pos] <= in_value;
    end
    if (cmd.issue) begin
      hist_q_r <= hist_mem[pos_r];
      coef_q_r <= coef_mem[cmd.tap_k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hvalid_r <= '0;
      newest_r <= '0;
      pos_r    <= '0;
      hq_ok_r  <= 1'b0;
    end else begin
      if (cmd.hist_clr) begin
        hvalid_r <= '0;
        newest_r <= '0;
      end else if (cmd.hist_wr) begin
        hvalid_r[next_pos] <= 1'b1;
        newest_r           <= next_pos;
        pos_r              <= next_pos;
      end else if (cmd.issue) begin
        hq_ok_r <= hvalid_r[pos_r];
        pos_r   <= (pos_r == '0) ? LAST_POS : pos_r - fir_pkg::TAP_W'(1);
      end
    end
  end

  assign hist_eff = hq_ok_r ? hist_q_r : '0;

  always_ff @(posedge clk) begin
    prod_r <= fir_pkg::PROD_W'(coef_q_r * hist_eff);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r   <= 1'b0;
      prod_v_r <= 1'b0;
    end else begin
      rd_v_r   <= cmd.issue;
      prod_v_r <= rd_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mac_start) begin
      acc_r <= '0;
    end else if (prod_v_r) begin
      acc_r <= acc_r + fir_pkg::ACC_W'(prod_r);
    end
  end

  // Round half up, then saturate when the bits above the result are not
  // all copies of its sign.
  always_comb begin
    rnd     = acc_r + (fir_pkg::ACC_W'(1) <<< (fir_pkg::FRAC - 1));
    fits    = (rnd[fir_pkg::ACC_W-1:fir_pkg::PROD_W-2] == '0) ||
              (rnd[fir_pkg::ACC_W-1:fir_pkg::PROD_W-2] == '1);
    sat_val = rnd[fir_pkg::ACC_W-1] ? {1'b1, {(fir_pkg::SAMPLE_BITS-1){1'b0}}}
                                    : {1'b0, {(fir_pkg::SAMPLE_BITS-1){1'b1}}};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_filtered_r <= fits ? rnd[fir_pkg::FRAC+fir_pkg::SAMPLE_BITS-1:fir_pkg::FRAC]
                             : sat_val;
      out_clipped_r  <= !fits;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_filtered = out_filtered_r;
  assign out_clipped  = out_clipped_r;
  assign sts.out_busy = out_valid_r && !out_ready;

endmodule

/* rtl/fir_convolution_filter.sv */
// ----------------------------------------------------------------------------
// FIR convolution filter
// Direct-form FIR filter with loadable coefficients and a circular history.
// ----------------------------------------------------------------------------
// Each request either loads one Q1.23 coefficient, clears the sample history,
// or filters one Q1.23 sample and returns one rounded, saturated result with a
// clip flag. A sample runs one multiply and accumulate per tap for n taps,
// where n is the tap count in use (one for a tap_count of zero, at most 256
// taps), through a single multiplier fed by one read port on each of the
// coefficient and history memories, then a pipeline drain and an output
// state. The filter takes no new request until the sample's result is
// loaded. The output state waits as long as the previous result is still
// held in the result register. The result register lets a new request in
// while the last result waits. Write tap_count only while the filter is idle.
module fir_convolution_filter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // coef_index[7:0], value[31:8]
  input  logic [1:0]  in_tuser,   // kind[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // filtered[23:0]
  output logic        out_tuser,  // clipped[0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [8:0]  cfg_data
);

  fir_pkg::cmd_t cmd;
  fir_pkg::sts_t sts;
  logic signed [fir_pkg::SAMPLE_BITS-1:0] filtered;

  fir_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_kind   (in_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .sts       (sts),
    .cmd       (cmd)
  );

  fir_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_coef_index (in_tdata[7:0]),
    .in_value      (in_tdata[31:8]),
    .out_ready     (out_tready),
    .out_valid     (out_tvalid),
    .out_filtered  (filtered),
    .out_clipped   (out_tuser),
    .sts           (sts)
  );

  assign out_tdata = filtered;

endmodule
